// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/e2c_pkg.sv =====
// ---------------------------------------------------------------------------
// e2c_pkg
// Shared constants, codes and the pipeline word of the cubemap sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package e2c_pkg;

    localparam int DEF_MAX_SRC_WIDTH  = 512;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_MAX_CHANNELS   = 4;

    // Field widths sized for the largest legal parameter values.
    localparam int ADDR_W = 23;
    localparam int COL_W  = 12;
    localparam int ROW_W  = 11;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic [1:0] REG_SRC_WIDTH     = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    localparam int CORDIC_STEPS = 15;
    localparam logic signed [31:0] DIR_ONE  = 32'sd2097152;
    localparam logic [15:0]        INV_GAIN = 16'd39797;

    typedef struct packed {
        logic                     ld;
        logic [31:0]              pix;
        logic [ADDR_W-1:0]        a_tl;
        logic [ADDR_W-1:0]        a_tr;
        logic [ADDR_W-1:0]        a_bl;
        logic [ADDR_W-1:0]        a_br;
        logic [2:0]               face;
        logic [11:0]              rem_u;
        logic [11:0]              rem_v;
        logic [15:0]              q_u;
        logic [15:0]              q_v;
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic signed [31:0]       dy;
        logic signed [31:0]       th;
        logic signed [17:0]       acc;
        logic [47:0]              prod;
        logic [20:0]              sxq;
        logic [20:0]              syq;
        logic [7:0]               fx;
        logic [7:0]               fy;
        logic [COL_W-1:0]         left;
        logic [COL_W-1:0]         right;
        logic [ROW_W-1:0]         top;
        logic [ROW_W-1:0]         bot;
        logic [3:0][15:0]         tv;
        logic [3:0][15:0]         bv;
        logic [3:0][8:0]          val;
    } t_item;

    function automatic logic signed [17:0] cordic_atan(input logic [3:0] i);
        case (i)
            4'd0:    return 18'sd8192;
            4'd1:    return 18'sd4836;
            4'd2:    return 18'sd2555;
            4'd3:    return 18'sd1297;
            4'd4:    return 18'sd651;
            4'd5:    return 18'sd326;
            4'd6:    return 18'sd163;
            4'd7:    return 18'sd81;
            4'd8:    return 18'sd41;
            4'd9:    return 18'sd20;
            4'd10:   return 18'sd10;
            4'd11:   return 18'sd5;
            4'd12:   return 18'sd3;
            4'd13:   return 18'sd1;
            4'd14:   return 18'sd1;
            default: return 18'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/e2c_ram.sv =====
// ---------------------------------------------------------------------------
// e2c_ram
// Simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module e2c_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/equirect_to_cubemap_sampler.sv =====
// Throughput: one word per cycle, loads and samples alike, set by the fully
// pipelined divider, two 15-step CORDIC chains and four replicated source RAMs.
// A result held on the output stalls the whole pipeline until it is taken.
// Reset clears valid bits and returns the registers to 512/256/3; the source
// memory is not cleared and must be loaded before it is sampled.
// ---------------------------------------------------------------------------
// equirect_to_cubemap_sampler
// Equirectangular panorama to cube face resampler with bilinear blending.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module equirect_to_cubemap_sampler #(
    parameter int MAX_SRC_WIDTH  = e2c_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = e2c_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_CHANNELS   = e2c_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_req_type,
    input  wire logic [8:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    input  wire logic [2:0]  i_face,
    input  wire logic [31:0] i_src_pixel,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_face_pixel,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NST    = 48;
    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int DW     = 8 * MAX_CHANNELS;
    localparam int ST_DIR = 9;
    localparam int ST_C1  = 10;
    localparam int ST_MUL = 25;
    localparam int ST_C2I = 26;
    localparam int ST_C2  = 27;
    localparam int ST_MAP = 42;
    localparam int ST_NB  = 43;
    localparam int ST_ADR = 44;
    localparam int ST_RD  = 45;
    localparam int ST_HOR = 46;
    localparam int ST_VER = 47;

    // -----------------------------------------------------------------------
    // Registers
    // -----------------------------------------------------------------------
    logic [9:0] r_src_width;
    logic [8:0] r_src_height;
    logic [2:0] r_channel_count;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width     <= 10'd512;
            r_src_height    <= 9'd256;
            r_channel_count <= 3'd3;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                e2c_pkg::REG_SRC_WIDTH:     r_src_width     <= pwdata[9:0];
                e2c_pkg::REG_SRC_HEIGHT:    r_src_height    <= pwdata[8:0];
                e2c_pkg::REG_CHANNEL_COUNT: r_channel_count <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            e2c_pkg::REG_SRC_WIDTH:     prdata = 32'(r_src_width);
            e2c_pkg::REG_SRC_HEIGHT:    prdata = 32'(r_src_height);
            e2c_pkg::REG_CHANNEL_COUNT: prdata = 32'(r_channel_count);
            default:                    prdata = 32'd0;
        endcase
    end

    // Effective geometry: registers clamped to the supported range, used directly by
    // every stage. The user keeps them stable while words are in flight; unchecked.
    logic [12:0] w_eff;
    logic [11:0] h_eff;
    logic [11:0] f_eff;
    logic [2:0]  ch_used;

    always_comb begin
        if (r_src_width < 10'd2) begin
            w_eff = 13'd2;
        end else if (32'(r_src_width) > MAX_SRC_WIDTH) begin
            w_eff = 13'(MAX_SRC_WIDTH);
        end else begin
            w_eff = 13'(r_src_width);
        end
        if (r_src_height < 9'd2) begin
            h_eff = 12'd2;
        end else if (32'(r_src_height) > MAX_SRC_HEIGHT) begin
            h_eff = 12'(MAX_SRC_HEIGHT);
        end else begin
            h_eff = 12'(r_src_height);
        end
        f_eff = {1'b0, h_eff[11:1]};
        if (r_channel_count < 3'd1) begin
            ch_used = 3'd1;
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            ch_used = 3'(MAX_CHANNELS);
        end else begin
            ch_used = r_channel_count;
        end
    end

    // -----------------------------------------------------------------------
    // Pipeline control: one global advance, stalled only by a held result
    // -----------------------------------------------------------------------
    e2c_pkg::t_item r_p [NST];
    e2c_pkg::t_item n_p [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] n_v;
    logic           adv;
    logic           r_out_vld;
    logic [31:0]    r_out_pix;
    logic [31:0]    n_out_pix;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_out_vld;
    assign o_face_pixel = r_out_pix;

    always_comb begin
        n_v[0] = i_valid && !o_stall &&
                 ((i_req_type == e2c_pkg::REQ_LOAD)
                    ? ((32'(i_pos_x) < MAX_SRC_WIDTH) && (32'(i_pos_y) < MAX_SRC_HEIGHT))
                    : (i_face <= e2c_pkg::FACE_NEG_Z));
        for (int k = 1; k < NST; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_v       <= n_v;
            r_out_vld <= r_v[NST-1] && !r_p[NST-1].ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p       <= n_p;
            r_out_pix <= n_out_pix;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 0: capture, clamp face position, seed the dividers
    // -----------------------------------------------------------------------
    always_comb begin : c_in
        logic [11:0] fm1;
        logic [11:0] pxe;
        logic [11:0] pye;
        fm1 = f_eff - 12'd1;
        pxe = 12'(i_pos_x);
        pye = 12'(i_pos_y);
        n_p[0]      = '0;
        n_p[0].ld   = (i_req_type == e2c_pkg::REQ_LOAD);
        n_p[0].pix  = i_src_pixel;
        n_p[0].a_tl = e2c_pkg::ADDR_W'(32'(i_pos_y) * 32'(MAX_SRC_WIDTH) + 32'(i_pos_x));
        n_p[0].face = i_face;
        // Position beyond the face: hold on the last column or row.
        n_p[0].rem_u = (pxe > fm1) ? fm1 : pxe;
        n_p[0].rem_v = (pye > fm1) ? fm1 : pye;
    end

    // -----------------------------------------------------------------------
    // Stages 1..8: ((2p+1) << 15) / F, two restoring steps per stage. The
    // upper part of the dividend is p itself, so the remainder starts at p.
    // -----------------------------------------------------------------------
    for (genvar gk = 1; gk <= 8; gk++) begin : g_div
        always_comb begin : c_div
            logic [11:0] ru;
            logic [11:0] rv;
            logic [15:0] qu;
            logic [15:0] qv;
            logic        bin;
            n_p[gk] = r_p[gk-1];
            ru = r_p[gk-1].rem_u;
            rv = r_p[gk-1].rem_v;
            qu = r_p[gk-1].q_u;
            qv = r_p[gk-1].q_v;
            for (int s = 0; s < 2; s++) begin
                bin = (gk == 1) && (s == 0);
                ru = {ru[10:0], bin};
                rv = {rv[10:0], bin};
                if (ru >= f_eff) begin
                    ru = ru - f_eff;
                    qu = {qu[14:0], 1'b1};
                end else begin
                    qu = {qu[14:0], 1'b0};
                end
                if (rv >= f_eff) begin
                    rv = rv - f_eff;
                    qv = {qv[14:0], 1'b1};
                end else begin
                    qv = {qv[14:0], 1'b0};
                end
            end
            n_p[gk].rem_u = ru;
            n_p[gk].rem_v = rv;
            n_p[gk].q_u   = qu;
            n_p[gk].q_v   = qv;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 9: direction vector, scaled by 64, and the quadrant pre-rotation
    // of the longitude CORDIC on (x, z)
    // -----------------------------------------------------------------------
    always_comb begin : c_dir
        logic signed [17:0] us;
        logic signed [17:0] vs;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        us = $signed({2'b00, r_p[ST_DIR-1].q_u}) - 18'sd32768;
        vs = $signed({2'b00, r_p[ST_DIR-1].q_v}) - 18'sd32768;
        u  = 32'(us) <<< 6;
        v  = 32'(vs) <<< 6;
        case (r_p[ST_DIR-1].face)
            e2c_pkg::FACE_POS_X: begin
                dx = e2c_pkg::DIR_ONE;  dy = -v;                dz = -u;
            end
            e2c_pkg::FACE_NEG_X: begin
                dx = -e2c_pkg::DIR_ONE; dy = -v;                dz = u;
            end
            e2c_pkg::FACE_POS_Y: begin
                dx = u;                 dy = e2c_pkg::DIR_ONE;  dz = v;
            end
            e2c_pkg::FACE_NEG_Y: begin
                dx = u;                 dy = -e2c_pkg::DIR_ONE; dz = -v;
            end
            e2c_pkg::FACE_POS_Z: begin
                dx = u;                 dy = -v;                dz = e2c_pkg::DIR_ONE;
            end
            default: begin
                dx = -u;                dy = -v;                dz = -e2c_pkg::DIR_ONE;
            end
        endcase
        n_p[ST_DIR]    = r_p[ST_DIR-1];
        n_p[ST_DIR].dy = dy;
        if (dx < 0) begin
            if (dz >= 0) begin
                n_p[ST_DIR].x   = dz;
                n_p[ST_DIR].y   = -dx;
                n_p[ST_DIR].acc = 18'sd16384;
            end else begin
                n_p[ST_DIR].x   = -dz;
                n_p[ST_DIR].y   = dx;
                n_p[ST_DIR].acc = -18'sd16384;
            end
        end else begin
            n_p[ST_DIR].x   = dx;
            n_p[ST_DIR].y   = dz;
            n_p[ST_DIR].acc = 18'sd0;
        end
    end

    function automatic e2c_pkg::t_item cordic_step(input e2c_pkg::t_item it,
                                                   input logic [3:0] i);
        e2c_pkg::t_item o;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        o  = it;
        xs = it.x >>> i;
        ys = it.y >>> i;
        if (it.y >= 0) begin
            o.x   = it.x + ys;
            o.y   = it.y - xs;
            o.acc = it.acc + e2c_pkg::cordic_atan(i);
        end else begin
            o.x   = it.x - ys;
            o.y   = it.y + xs;
            o.acc = it.acc - e2c_pkg::cordic_atan(i);
        end
        return o;
    endfunction

    // Stages 10..24: longitude CORDIC, one iteration per stage
    for (genvar gi = 0; gi < e2c_pkg::CORDIC_STEPS; gi++) begin : g_cor1
        always_comb begin
            n_p[ST_C1+gi] = cordic_step(r_p[ST_C1+gi-1], 4'(gi));
        end
    end

    // Stage 25: keep theta, scale the (x, z) magnitude by the inverse gain
    always_comb begin : c_mul
        logic [31:0] r;
        r = (r_p[ST_MUL-1].x < 0) ? 32'd0 : r_p[ST_MUL-1].x;
        n_p[ST_MUL]      = r_p[ST_MUL-1];
        n_p[ST_MUL].th   = 32'(r_p[ST_MUL-1].acc);
        n_p[ST_MUL].prod = 48'(r) * 48'(e2c_pkg::INV_GAIN);
    end

    // Stage 26: seed the latitude CORDIC with (radius, y); radius is never negative
    always_comb begin
        n_p[ST_C2I]     = r_p[ST_C2I-1];
        n_p[ST_C2I].x   = $signed(r_p[ST_C2I-1].prod[47:16]);
        n_p[ST_C2I].y   = r_p[ST_C2I-1].dy;
        n_p[ST_C2I].acc = 18'sd0;
    end

    // Stages 27..41: latitude CORDIC
    for (genvar gj = 0; gj < e2c_pkg::CORDIC_STEPS; gj++) begin : g_cor2
        always_comb begin
            n_p[ST_C2+gj] = cordic_step(r_p[ST_C2+gj-1], 4'(gj));
        end
    end

    // -----------------------------------------------------------------------
    // Stage 42: angles to source coordinates with 8 fraction bits
    // -----------------------------------------------------------------------
    always_comb begin : c_map
        logic signed [17:0] phi;
        logic [15:0]        t;
        logic [15:0]        pol;
        if (r_p[ST_MAP-1].acc > 18'sd16384) begin
            phi = 18'sd16384;
        end else if (r_p[ST_MAP-1].acc < -18'sd16384) begin
            phi = -18'sd16384;
        end else begin
            phi = r_p[ST_MAP-1].acc;
        end
        t   = r_p[ST_MAP-1].th[15:0] + 16'h8000;
        pol = 16'(18'sd16384 - phi);
        n_p[ST_MAP]     = r_p[ST_MAP-1];
        n_p[ST_MAP].sxq = 21'((32'(t) * 32'(w_eff)) >> 8);
        n_p[ST_MAP].syq = 21'((32'(pol) * 32'(h_eff)) >> 7);
    end

    // -----------------------------------------------------------------------
    // Stage 43: neighbours, columns wrapped, rows clamped at the poles
    // -----------------------------------------------------------------------
    always_comb begin : c_nb
        logic signed [21:0] sx;
        logic signed [21:0] sy;
        logic signed [14:0] bx;
        logic signed [14:0] by;
        logic signed [14:0] bx1;
        logic signed [14:0] by1;
        logic signed [14:0] ws;
        logic signed [14:0] hs;
        logic signed [14:0] lf;
        logic signed [14:0] rt;
        logic signed [14:0] tp;
        logic signed [14:0] bt;
        sx  = $signed({1'b0, r_p[ST_NB-1].sxq}) - 22'sd128;
        sy  = $signed({1'b0, r_p[ST_NB-1].syq}) - 22'sd128;
        bx  = 15'(sx >>> 8);
        by  = 15'(sy >>> 8);
        bx1 = bx + 15'sd1;
        by1 = by + 15'sd1;
        ws  = $signed({2'b00, w_eff});
        hs  = $signed({3'b000, h_eff});
        if (bx < 0) begin
            lf = ws - 15'sd1;
        end else if (bx >= ws) begin
            lf = bx - ws;
        end else begin
            lf = bx;
        end
        if (lf >= ws) begin
            lf = ws - 15'sd1;
        end
        rt = (bx1 >= ws) ? (bx1 - ws) : bx1;
        if (rt >= ws) begin
            rt = ws - 15'sd1;
        end
        if (by < 0) begin
            tp = 15'sd0;
        end else if (by > hs - 15'sd1) begin
            tp = hs - 15'sd1;
        end else begin
            tp = by;
        end
        if (by1 < 0) begin
            bt = 15'sd0;
        end else if (by1 > hs - 15'sd1) begin
            bt = hs - 15'sd1;
        end else begin
            bt = by1;
        end
        n_p[ST_NB]       = r_p[ST_NB-1];
        n_p[ST_NB].fx    = sx[7:0];
        n_p[ST_NB].fy    = sy[7:0];
        n_p[ST_NB].left  = e2c_pkg::COL_W'(lf);
        n_p[ST_NB].right = e2c_pkg::COL_W'(rt);
        n_p[ST_NB].top   = e2c_pkg::ROW_W'(tp);
        n_p[ST_NB].bot   = e2c_pkg::ROW_W'(bt);
    end

    // Stage 44: word addresses; a load keeps its own address in a_tl
    always_comb begin
        n_p[ST_ADR] = r_p[ST_ADR-1];
        if (!r_p[ST_ADR-1].ld) begin
            n_p[ST_ADR].a_tl = e2c_pkg::ADDR_W'(32'(r_p[ST_ADR-1].top) * 32'(MAX_SRC_WIDTH)
                                                + 32'(r_p[ST_ADR-1].left));
            n_p[ST_ADR].a_tr = e2c_pkg::ADDR_W'(32'(r_p[ST_ADR-1].top) * 32'(MAX_SRC_WIDTH)
                                                + 32'(r_p[ST_ADR-1].right));
            n_p[ST_ADR].a_bl = e2c_pkg::ADDR_W'(32'(r_p[ST_ADR-1].bot) * 32'(MAX_SRC_WIDTH)
                                                + 32'(r_p[ST_ADR-1].left));
            n_p[ST_ADR].a_br = e2c_pkg::ADDR_W'(32'(r_p[ST_ADR-1].bot) * 32'(MAX_SRC_WIDTH)
                                                + 32'(r_p[ST_ADR-1].right));
        end
    end

    // -----------------------------------------------------------------------
    // Source memory: four copies, one per neighbour, all written by each load.
    // Loads write at the read stage, so program order is kept against samples.
    // -----------------------------------------------------------------------
    logic          mem_we;
    logic [DW-1:0] rd_tl;
    logic [DW-1:0] rd_tr;
    logic [DW-1:0] rd_bl;
    logic [DW-1:0] rd_br;

    assign mem_we = adv && r_v[ST_ADR] && r_p[ST_ADR].ld;

    e2c_ram #(.DATA_W(DW), .DEPTH(DEPTH)) u_ram_tl (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_p[ST_ADR].a_tl[AW-1:0]),
        .i_wdata (r_p[ST_ADR].pix[DW-1:0]),
        .i_re    (adv),
        .i_raddr (r_p[ST_ADR].a_tl[AW-1:0]),
        .o_rdata (rd_tl)
    );

    e2c_ram #(.DATA_W(DW), .DEPTH(DEPTH)) u_ram_tr (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_p[ST_ADR].a_tl[AW-1:0]),
        .i_wdata (r_p[ST_ADR].pix[DW-1:0]),
        .i_re    (adv),
        .i_raddr (r_p[ST_ADR].a_tr[AW-1:0]),
        .o_rdata (rd_tr)
    );

    e2c_ram #(.DATA_W(DW), .DEPTH(DEPTH)) u_ram_bl (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_p[ST_ADR].a_tl[AW-1:0]),
        .i_wdata (r_p[ST_ADR].pix[DW-1:0]),
        .i_re    (adv),
        .i_raddr (r_p[ST_ADR].a_bl[AW-1:0]),
        .o_rdata (rd_bl)
    );

    e2c_ram #(.DATA_W(DW), .DEPTH(DEPTH)) u_ram_br (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_p[ST_ADR].a_tl[AW-1:0]),
        .i_wdata (r_p[ST_ADR].pix[DW-1:0]),
        .i_re    (adv),
        .i_raddr (r_p[ST_ADR].a_br[AW-1:0]),
        .o_rdata (rd_br)
    );

    // Stage 45: travels alongside the registered RAM read
    always_comb begin
        n_p[ST_RD] = r_p[ST_RD-1];
    end

    // Split RAM words into channel bytes; lanes beyond the parameter read zero
    logic [3:0][7:0] b_tl;
    logic [3:0][7:0] b_tr;
    logic [3:0][7:0] b_bl;
    logic [3:0][7:0] b_br;

    for (genvar gc = 0; gc < 4; gc++) begin : g_lane
        if (gc < MAX_CHANNELS) begin : g_used
            assign b_tl[gc] = rd_tl[8*gc +: 8];
            assign b_tr[gc] = rd_tr[8*gc +: 8];
            assign b_bl[gc] = rd_bl[8*gc +: 8];
            assign b_br[gc] = rd_br[8*gc +: 8];
        end else begin : g_unused
            assign b_tl[gc] = 8'd0;
            assign b_tr[gc] = 8'd0;
            assign b_bl[gc] = 8'd0;
            assign b_br[gc] = 8'd0;
        end
    end

    // Stage 46: horizontal blend per channel
    always_comb begin : c_hor
        logic [8:0] wx;
        logic [8:0] wxn;
        wx  = {1'b0, r_p[ST_HOR-1].fx};
        wxn = 9'd256 - wx;
        n_p[ST_HOR] = r_p[ST_HOR-1];
        for (int c = 0; c < 4; c++) begin
            n_p[ST_HOR].tv[c] = 16'(17'(b_tl[c]) * 17'(wxn) + 17'(b_tr[c]) * 17'(wx));
            n_p[ST_HOR].bv[c] = 16'(17'(b_bl[c]) * 17'(wxn) + 17'(b_br[c]) * 17'(wx));
        end
    end

    // Stage 47: vertical blend and rounding
    always_comb begin : c_ver
        logic [8:0] wy;
        logic [8:0] wyn;
        wy  = {1'b0, r_p[ST_VER-1].fy};
        wyn = 9'd256 - wy;
        n_p[ST_VER] = r_p[ST_VER-1];
        for (int c = 0; c < 4; c++) begin
            n_p[ST_VER].val[c] = 9'((26'(r_p[ST_VER-1].tv[c]) * 26'(wyn)
                                     + 26'(r_p[ST_VER-1].bv[c]) * 26'(wy)
                                     + 26'd32768) >> 16);
        end
    end

    // Output word: saturate, drop bytes past the channel count
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (3'(c) < ch_used) begin
                n_out_pix[8*c +: 8] = (r_p[NST-1].val[c] > 9'd255) ? 8'hFF
                                                                   : r_p[NST-1].val[c][7:0];
            end else begin
                n_out_pix[8*c +: 8] = 8'd0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ASSERT_IMPLIES(a_stall_only_on_held, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_NEXT(a_out_from_sample, i_clk, i_rst_n, adv && !(r_v[NST-1] && !r_p[NST-1].ld), !o_valid)
    `ASSERT_IMPLIES(a_unused_bytes_zero, i_clk, i_rst_n, o_valid && (ch_used == 3'd1), o_face_pixel[31:8] == 24'd0)

endmodule

`default_nettype wire

// ===== sim/equirect_to_cubemap_sampler_test.sv =====
// ---------------------------------------------------------------------------
// Cubemap sampler testbench
// Loads source pixels and samples cube faces over several register settings,
// with a predictor of the direction, CORDIC and bilinear blend arithmetic in
// step with every accepted word. Each result is checked in order.
// ---------------------------------------------------------------------------
`default_nettype none

module equirect_to_cubemap_sampler_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_W     = 512;
    localparam int LIMIT     = 2000000;
    localparam int SETTLE    = 60;   // outlasts the pipeline
    localparam int HOLD_OFF  = 300;

    typedef struct {
        logic        req;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [2:0]  face;
        logic [31:0] pix;
        bit          known;
        logic [31:0] want;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_req_type;
    logic [8:0]  i_pos_x;
    logic [7:0]  i_pos_y;
    logic [2:0]  i_face;
    logic [31:0] i_src_pixel;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_face_pixel;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    equirect_to_cubemap_sampler DUT (.*);

    // Predictor state: registers as written, source image as loaded.
    int unsigned      width_reg, height_reg, chan_reg;
    logic [31:0]      image [int];
    bit               loaded [int];      // what the stimulus has already queued
    logic [31:0]      pixel_q [$];       // expected face pixels, oldest first
    t_word            word_q [$];        // stimulus waiting to be sent
    t_word            cur;

    int unsigned cycles, n_in, n_out, n_samples, n_phases, errors;
    bit          held;

    const int atan_steps [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41,
                                  20, 10, 5, 3, 1, 1};

    // Directed rows on a 2x2 source, four channels. Uniform neighbours give
    // the result at a glance; the mixed rows go through the predictor.
    const t_word dir_tab [22] = '{
      '{e2c_pkg::REQ_LOAD, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd1, 8'd0, e2c_pkg::FACE_POS_X, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd0, 8'd1, e2c_pkg::FACE_POS_X, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd1, 8'd1, e2c_pkg::FACE_POS_X, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd511, 8'd255, e2c_pkg::FACE_NEG_X, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd255, e2c_pkg::FACE_POS_Y, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd511, 8'd0, e2c_pkg::FACE_NEG_Y, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd256, 8'd128, e2c_pkg::FACE_POS_Z, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd1, 8'd1, e2c_pkg::FACE_NEG_Z, 32'h0, 1'b1, 32'hFFFFFFFF},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, 3'd6, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd511, 8'd255, 3'd7, 32'hFFFFFFFF, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd1, 8'd0, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd0, 8'd1, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd1, 8'd1, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, e2c_pkg::FACE_POS_Z, 32'h0, 1'b1, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'h12345678, 1'b0, 32'h0},
      '{e2c_pkg::REQ_LOAD, 9'd1, 8'd1, e2c_pkg::FACE_POS_X, 32'h80FF00A5, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, e2c_pkg::FACE_POS_Y, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, e2c_pkg::FACE_NEG_Y, 32'h0, 1'b0, 32'h0},
      '{e2c_pkg::REQ_SAMPLE, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0}
    };

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Vectoring CORDIC: angle in 1/65536 turn, magnitude carries the gain.
    function automatic int vec_angle(input int x0, input int y0, output int mag);
        int x, y, nx, ny, acc, t;
        x = x0; y = y0; acc = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; acc = 16384;
            end else begin
                t = x; x = -y; y = t; acc = -16384;
            end
        end
        for (int i = 0; i < 15; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); acc += atan_steps[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); acc -= atan_steps[i];
            end
            x = nx; y = ny;
        end
        mag = x;
        return acc;
    endfunction

    // Map a face position to its four source neighbours and blend weights.
    function automatic void locate(input int px_in, input int py_in, input logic [2:0] fc,
                                   output int lft, output int rgt, output int tp,
                                   output int bt, output int fx, output int fy);
        int w, h, f, px, py, u, v, dx, dy, dz, r, r2, theta, phi, sx, sy, bx, by;
        int unsigned t, sxq, syq;
        w = clip(width_reg, 2, 512);
        h = clip(height_reg, 2, 256);
        f = h >> 1;
        px = px_in > f - 1 ? f - 1 : px_in;
        py = py_in > f - 1 ? f - 1 : py_in;
        u = ((2 * px + 1) << 15) / f - 32768;
        v = ((2 * py + 1) << 15) / f - 32768;
        case (fc)
            e2c_pkg::FACE_POS_X: begin dx = 32768;  dy = -v;     dz = -u;     end
            e2c_pkg::FACE_NEG_X: begin dx = -32768; dy = -v;     dz = u;      end
            e2c_pkg::FACE_POS_Y: begin dx = u;      dy = 32768;  dz = v;      end
            e2c_pkg::FACE_NEG_Y: begin dx = u;      dy = -32768; dz = -v;     end
            e2c_pkg::FACE_POS_Z: begin dx = u;      dy = -v;     dz = 32768;  end
            default:             begin dx = -u;     dy = -v;     dz = -32768; end
        endcase
        theta = vec_angle(dx * 64, dz * 64, r);
        if (r < 0) r = 0;
        r = int'((longint'(r) * 39797) >>> 16);
        phi = vec_angle(r, dy * 64, r2);
        if (phi > 16384) phi = 16384;
        if (phi < -16384) phi = -16384;
        t = (theta + 32768) & 32'hFFFF;
        sxq = (t * w) >> 8;
        syq = ((16384 - phi) * h) >> 7;
        sx = int'(sxq) - 128;
        sy = int'(syq) - 128;
        bx = sx >>> 8; fx = sx & 255;
        by = sy >>> 8; fy = sy & 255;
        lft = bx < 0 ? w - 1 : (bx >= w ? bx - w : bx);
        rgt = bx + 1 >= w ? bx + 1 - w : bx + 1;
        tp  = by < 0 ? 0 : (by > h - 1 ? h - 1 : by);
        bt  = by + 1 < 0 ? 0 : (by + 1 > h - 1 ? h - 1 : by + 1);
        if (lft >= w) lft = w - 1;
        if (rgt >= w) rgt = w - 1;
    endfunction

    function automatic logic [31:0] blend_pixel(int px, int py, logic [2:0] fc);
        int lft, rgt, tp, bt, fx, fy, c;
        int unsigned tl, tr, bl, br, tv, bv, val;
        logic [31:0] res;
        locate(px, py, fc, lft, rgt, tp, bt, fx, fy);
        c = clip(chan_reg, 1, 4);
        res = '0;
        for (int ch = 0; ch < c; ch++) begin
            tl = (image[tp * MEM_W + lft] >> (8 * ch)) & 8'hFF;
            tr = (image[tp * MEM_W + rgt] >> (8 * ch)) & 8'hFF;
            bl = (image[bt * MEM_W + lft] >> (8 * ch)) & 8'hFF;
            br = (image[bt * MEM_W + rgt] >> (8 * ch)) & 8'hFF;
            tv = tl * (256 - fx) + tr * fx;
            bv = bl * (256 - fx) + br * fx;
            val = (tv * (256 - fy) + bv * fy + 32768) >> 16;
            if (val > 255) val = 255;
            res |= val << (8 * ch);
        end
        return res;
    endfunction

    function automatic void queue_load(int col, int row);
        t_word wd;
        wd = '{e2c_pkg::REQ_LOAD, col[8:0], row[7:0], 3'($urandom_range(0, 7)), $urandom,
               1'b0, 32'h0};
        loaded[row * MEM_W + col] = 1'b1;
        word_q.push_back(wd);
    endfunction

    // Random phase of at least count words: mostly samples, each preceded by
    // the loads that its neighbours still lack; the rest are stray loads and
    // ignored faces.
    function automatic void queue_random(int count);
        int f, px, py, lft, rgt, tp, bt, fx, fy;
        logic [2:0] fc;
        t_word wd;
        f = clip(height_reg, 2, 256) >> 1;
        while (word_q.size() < count) begin
            if ($urandom_range(0, 99) < 12) begin
                queue_load($urandom_range(0, 511), $urandom_range(0, 255));
            end else begin
                px = $urandom_range(0, 9) == 0 ? $urandom_range(0, 511)
                                               : $urandom_range(0, f - 1);
                py = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                               : $urandom_range(0, f - 1);
                fc = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
                if (fc <= e2c_pkg::FACE_NEG_Z) begin
                    locate(px, py, fc, lft, rgt, tp, bt, fx, fy);
                    if (!loaded.exists(tp * MEM_W + lft)) queue_load(lft, tp);
                    if (!loaded.exists(tp * MEM_W + rgt)) queue_load(rgt, tp);
                    if (!loaded.exists(bt * MEM_W + lft)) queue_load(lft, bt);
                    if (!loaded.exists(bt * MEM_W + rgt)) queue_load(rgt, bt);
                end
                wd = '{e2c_pkg::REQ_SAMPLE, px[8:0], py[7:0], fc, $urandom, 1'b0, 32'h0};
                word_q.push_back(wd);
            end
        end
    endfunction

    // Clock and run limit
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Input side: update the image on loads, predict on samples.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            n_in <= n_in + 1;
            if (cur.req == e2c_pkg::REQ_LOAD) begin
                image[int'(cur.y) * MEM_W + int'(cur.x)] = cur.pix;
            end else if (cur.face <= e2c_pkg::FACE_NEG_Z) begin
                pixel_q.push_back(cur.known ? cur.want
                                            : blend_pixel(cur.x, cur.y, cur.face));
                n_samples <= n_samples + 1;
            end
        end
    end

    // Output side: compare each taken word with the oldest expectation.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_out <= n_out + 1;
            if (pixel_q.size() == 0) begin
                errors = errors + 1;
                if (errors <= 10)
                    $display("face_pixel: expected none, got %h", o_face_pixel);
            end else begin
                want = pixel_q.pop_front();
                if (o_face_pixel !== want) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("face_pixel: expected %h, got %h", want, o_face_pixel);
                end
            end
        end
    end

    // Receiver: stall on changing patterns; once, hold off long enough to
    // fill the pipeline and push back on the sender.
    initial begin
        int mode;
        i_stall = 1'b0;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 64; k++) begin
                @(negedge i_clk);
                if (!held && n_in >= 700) begin
                    i_stall <= 1'b1;
                    repeat (HOLD_OFF) @(negedge i_clk);
                    held = 1'b1;
                    i_stall <= 1'b0;
                end else begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= $urandom_range(0, 3) == 0;
                        2: i_stall <= $urandom_range(0, 3) != 0;
                        default: i_stall <= k[1];
                    endcase
                end
            end
        end
    end

    // Register access: setup then access, read back what was written.
    task automatic reg_access(logic [1:0] idx, int unsigned value, logic wr);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= wr; paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== value) begin
            errors = errors + 1;
            if (errors <= 10)
                $display("register %0d: expected %h, got %h", idx, value, prdata);
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_regs(int unsigned w, int unsigned h, int unsigned c);
        reg_access(e2c_pkg::REG_SRC_WIDTH, w & 10'h3FF, 1'b1);
        reg_access(e2c_pkg::REG_SRC_HEIGHT, h & 9'h1FF, 1'b1);
        reg_access(e2c_pkg::REG_CHANNEL_COUNT, c & 3'h7, 1'b1);
        width_reg = w & 10'h3FF;
        height_reg = h & 9'h1FF;
        chan_reg = c & 3'h7;
        reg_access(e2c_pkg::REG_SRC_WIDTH, width_reg, 1'b0);
        reg_access(e2c_pkg::REG_SRC_HEIGHT, height_reg, 1'b0);
        reg_access(e2c_pkg::REG_CHANNEL_COUNT, chan_reg, 1'b0);
        n_phases++;
    endtask

    // Sender: bursts of random length with random gaps; drop valid only
    // for a gap, never between two words of a burst.
    task automatic send_all();
        int burst;
        burst = 0;
        while (word_q.size() != 0) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                end
            end
            cur = word_q.pop_front();
            i_valid <= 1'b1;
            i_req_type <= cur.req;
            i_pos_x <= cur.x;
            i_pos_y <= cur.y;
            i_face <= cur.face;
            i_src_pixel <= cur.pix;
            do @(posedge i_clk); while (o_stall);
            @(negedge i_clk);
            burst--;
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        cycles = 0; n_in = 0; n_out = 0; n_samples = 0; n_phases = 0; errors = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_req_type = e2c_pkg::REQ_LOAD; i_pos_x = '0; i_pos_y = '0;
        i_face = e2c_pkg::FACE_POS_X; i_src_pixel = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cur = '{e2c_pkg::REQ_LOAD, 9'd0, 8'd0, e2c_pkg::FACE_POS_X, 32'h0, 1'b0, 32'h0};
        width_reg = 512; height_reg = 256; chan_reg = 3;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values first, then the directed rows on the smallest source.
        reg_access(e2c_pkg::REG_SRC_WIDTH, 512, 1'b0);
        reg_access(e2c_pkg::REG_SRC_HEIGHT, 256, 1'b0);
        reg_access(e2c_pkg::REG_CHANNEL_COUNT, 3, 1'b0);
        set_regs(2, 2, 4);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].req == e2c_pkg::REQ_LOAD)
                loaded[int'(dir_tab[i].y) * MEM_W + int'(dir_tab[i].x)] = 1'b1;
            word_q.push_back(dir_tab[i]);
        end
        send_all();
        drain();

        // Random phases across settings, out-of-range values among them.
        set_regs(512, 256, 3);   queue_random(360); send_all(); drain();
        set_regs(3, 2, 1);       queue_random(100); send_all(); drain();
        set_regs(0, 0, 0);       queue_random(100); send_all(); drain();
        set_regs(1023, 511, 7);  queue_random(360); send_all(); drain();
        set_regs(37, 20, 2);     queue_random(250); send_all(); drain();
        set_regs(512, 256, 4);   queue_random(250); send_all(); drain();

        $display("%0d words in, %0d face pixels predicted, %0d taken, over %0d settings",
                 n_in, n_samples, n_out, n_phases);
        $display("%0d cycles, %0d mismatches", cycles, errors);
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== equirect_to_cubemap_sampler.f =====
+incdir+rtl
rtl/e2c_pkg.sv
rtl/e2c_ram.sv
rtl/equirect_to_cubemap_sampler.sv
sim/equirect_to_cubemap_sampler_test.sv
